// ----- rtl/rwvd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rwvd_pkg;

   // register type codes
   typedef enum logic [2:0] {
      CMD_U64  = 3'd0,
      CMD_S64  = 3'd1,
      CMD_U32  = 3'd2,
      CMD_S32  = 3'd3,
      CMD_FP32 = 3'd4,
      CMD_U16  = 3'd5,
      CMD_S16  = 3'd6,
      CMD_B16  = 3'd7
   } cmd_type;

   // widths
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned MANT_W   = 24;
   localparam int unsigned PROD_W   = 34;
   localparam int unsigned SHIFT_W  = 10;

   // most register words that are packed
   localparam int unsigned MAX_WORDS = 4;

   // invalid markers
   localparam logic [63:0] U64_INVALID = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_INVALID = 64'h8000_0000_0000_0000;
   localparam logic [31:0] U32_INVALID = 32'hFFFF_FFFF;
   localparam logic [31:0] S32_INVALID = 32'h8000_0000;

   // single precision fields and scaling
   localparam logic [7:0]  EXP_MAX     = 8'hFF;
   localparam logic [9:0]  FP_SCALE    = 10'd1000;
   localparam logic [9:0]  EXP_OFFSET  = 10'd150;
   localparam logic [9:0]  SHIFT_SAT   = 10'd40;
   localparam logic [9:0]  SHIFT_ZERO  = 10'd24;
   localparam logic [63:0] VALUE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] VALUE_MIN   = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

// ----- rtl/register_word_value_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | ports                                    | beat taken when
// req     | in        | req_cmd, req_word_count, req_word0..3    | req_valid & !req_stall
// rsp     | out       | rsp_value                                | rsp_valid & !rsp_stall
//
// five register stages: pack, type decode and scale multiply, round to
// single precision, shift, sign and saturate into the output register
// one beat per cycle sustained while rsp_stall is low
// each stage moves on when empty or when the one after it moves, so bubbles
// close up and a held output beat leaves earlier stages filling
// reset clears the valid bits only

module register_word_value_decoder_unit
   import rwvd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_cmd,
   input  wire logic [2:0]            req_word_count,
   input  wire logic [WORD_W-1:0]     req_word0,
   input  wire logic [WORD_W-1:0]     req_word1,
   input  wire logic [WORD_W-1:0]     req_word2,
   input  wire logic [WORD_W-1:0]     req_word3,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_value
);

   // stage enables, back to front
   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;

   assign en5 = !rsp_valid_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   // stage 1: pack words first word most significant
   cmd_type            cmd1_ff;
   logic [VALUE_W-1:0] acc1_ff, acc1_in;
   logic [WORD_W-1:0]  w01_ff;
   logic [2:0]         cnt_in;

   always_comb begin
      cnt_in = (req_word_count > 3'(MAX_WORDS)) ? 3'(MAX_WORDS) : req_word_count;
      case (cnt_in)
         3'd0: acc1_in = '0;
         3'd1: acc1_in = {48'd0, req_word0};
         3'd2: acc1_in = {32'd0, req_word0, req_word1};
         3'd3: acc1_in = {16'd0, req_word0, req_word1, req_word2};
         default: acc1_in = {req_word0, req_word1, req_word2, req_word3};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
      if (en1) begin
         cmd1_ff <= cmd_type'(req_cmd);
         acc1_ff <= acc1_in;
         w01_ff  <= req_word0;
      end
   end

   // stage 2: integer types and significand times the scale
   logic               fp2_ff, fp2_in;
   logic [VALUE_W-1:0] int2_ff, int2_in;
   logic               neg2_ff;
   logic [7:0]         e2_ff;
   logic [PROD_W-1:0]  p2_ff, p2_in;
   logic [31:0]        a32;
   logic [7:0]         e_in;

   assign a32  = acc1_ff[31:0];
   assign e_in = a32[30:23];
   assign p2_in = PROD_W'({1'b1, a32[22:0]}) * PROD_W'(FP_SCALE);

   always_comb begin
      fp2_in  = 1'b0;
      int2_in = '0;
      case (cmd1_ff)
         CMD_U64:  int2_in = (acc1_ff == U64_INVALID) ? '0 : acc1_ff;
         CMD_S64:  int2_in = (acc1_ff == S64_INVALID) ? '0 : acc1_ff;
         CMD_U32:  int2_in = (a32 == U32_INVALID) ? '0 : {32'd0, a32};
         CMD_S32:  int2_in = (a32 == S32_INVALID) ? '0 : {{32{a32[31]}}, a32};
         CMD_FP32: fp2_in  = (e_in != 8'd0) && (e_in != EXP_MAX);
         CMD_S16:  int2_in = {{48{w01_ff[15]}}, w01_ff};
         CMD_U16, CMD_B16: int2_in = {48'd0, w01_ff};
         default:  int2_in = {48'd0, w01_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         fp2_ff  <= fp2_in;
         int2_ff <= int2_in;
         neg2_ff <= a32[31];
         e2_ff   <= e_in;
         p2_ff   <= p2_in;
      end
   end

   // stage 3: round product to 24 bits, nearest even, and work out the shift
   logic               fp3_ff, neg3_ff;
   logic [VALUE_W-1:0] int3_ff;
   logic [MANT_W-1:0]  r3_ff, r3_in, r_base;
   logic signed [SHIFT_W-1:0] s3_ff, s3_in;
   logic               big;
   logic [9:0]         rem, half;
   logic               round_up;
   logic [MANT_W:0]    r_sum;

   always_comb begin
      big      = p2_ff[PROD_W-1];
      r_base   = big ? p2_ff[33:10] : p2_ff[32:9];
      rem      = big ? p2_ff[9:0] : {1'b0, p2_ff[8:0]};
      half     = big ? 10'h200 : 10'h100;
      round_up = (rem > half) || ((rem == half) && r_base[0]);
      r_sum    = {1'b0, r_base} + {{MANT_W{1'b0}}, round_up};
      r3_in    = r_sum[MANT_W] ? r_sum[MANT_W:1] : r_sum[MANT_W-1:0];
      s3_in    = $signed(10'(e2_ff) + 10'd9 + 10'(big) + 10'(r_sum[MANT_W]) - EXP_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         fp3_ff  <= fp2_ff;
         neg3_ff <= neg2_ff;
         int3_ff <= int2_ff;
         r3_ff   <= r3_in;
         s3_ff   <= s3_in;
      end
   end

   // stage 4: scale the rounded significand into a magnitude
   logic               fp4_ff, neg4_ff, sat4_ff, sat4_in;
   logic [VALUE_W-1:0] int4_ff, mag4_ff, mag4_in;
   logic [SHIFT_W-1:0] rshift;

   always_comb begin
      rshift  = 10'(-s3_ff);
      sat4_in = (s3_ff >= $signed(SHIFT_SAT));
      if (!s3_ff[SHIFT_W-1]) begin
         mag4_in = {40'd0, r3_ff} << s3_ff[5:0];
      end else if (rshift >= SHIFT_ZERO) begin
         mag4_in = '0;
      end else begin
         mag4_in = {40'd0, r3_ff >> rshift[4:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         fp4_ff  <= fp3_ff;
         neg4_ff <= neg3_ff;
         int4_ff <= int3_ff;
         sat4_ff <= sat4_in;
         mag4_ff <= mag4_in;
      end
   end

   // stage 5: sign, saturate and pick the result into the output register
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   always_comb begin
      if (!fp4_ff) begin
         rsp_value_in = int4_ff;
      end else if (sat4_ff) begin
         rsp_value_in = neg4_ff ? VALUE_MIN : VALUE_MAX;
      end else begin
         rsp_value_in = neg4_ff ? (~mag4_ff + 64'd1) : mag4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en5) begin
         rsp_valid_ff <= v4_ff;
      end
      if (en5) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = $signed(rsp_value_ff);

   // checks
   a_round_normalised: assert property (@(posedge clock) disable iff (reset)
      v3_ff && fp3_ff |-> r3_ff[MANT_W-1])
      else $error("rounded significand lost its leading one");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff && fp3_ff |-> (s3_ff >= -10'sd140) && (s3_ff <= 10'sd115))
      else $error("scale shift out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid && rsp_stall)
      else $error("input held back with room in the pipeline");

   a_fp_sign: assert property (@(posedge clock) disable iff (reset)
      v4_ff && fp4_ff && !sat4_ff && !neg4_ff && en5 |=> !rsp_value_ff[VALUE_W-1])
      else $error("positive single gave a negative result");

endmodule

`default_nettype wire
